// File: src/rbf_pkg.sv
// package for the row box filter: item types, widths and register indexes
// no dependencies; imported by every module of the block
package rbf_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_HALF_WIDTH = 15;
    localparam int HW_BITS        = 4;
    localparam int WIN_DEPTH      = 2 * MAX_HALF_WIDTH + 1;
    localparam int WIN_IDX_BITS   = $clog2(WIN_DEPTH);
    localparam int POS_BITS       = 5;
    localparam int POS_LIMIT      = 2 * MAX_HALF_WIDTH + 1;
    localparam int SUM_BITS       = 21;
    localparam int RECIP_BITS     = 24;
    localparam int RECIP_FRAC     = 24;
    localparam int PROD_BITS      = SUM_BITS + RECIP_BITS;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [HW_BITS-1:0]    HALF_WIDTH_RESET = HW_BITS'(1);
    localparam logic [RECIP_BITS-1:0] RECIP_RESET      = RECIP_BITS'(5592405);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WIDTH = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RECIP      = 1'b1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   row_end;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] mean;
        logic                   last_of_row;
    } out_item_t;

    // window sum waiting for scaling, with its end-of-row flag
    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic                last;
    } acc_item_t;

    typedef enum logic {
        PH_STREAM,
        PH_FLUSH
    } phase_t;

endpackage

// File: src/rbf_cell.sv
// one sample cell of the window shift line
// uses rbf_pkg for the sample width
module rbf_cell (
    input  logic                            clk,
    input  logic                            shift,
    input  logic [rbf_pkg::SAMPLE_BITS-1:0] d,
    output logic [rbf_pkg::SAMPLE_BITS-1:0] q
);
    import rbf_pkg::*;

    logic [SAMPLE_BITS-1:0] sample_reg;

    // holds the sample; takes the value on d on every step
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            sample_reg <= d;
        end
    end

    assign q = sample_reg;

endmodule

// File: src/rbf_scale.sv
// scaling pipeline: window sum times reciprocal, then truncate and saturate
// uses rbf_pkg; two registered stages with valid/ready between them
module rbf_scale (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [rbf_pkg::RECIP_BITS-1:0] recip,
    input  logic                           acc_valid,
    output logic                           acc_ready,
    input  rbf_pkg::acc_item_t             acc_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rbf_pkg::out_item_t             out_item
);
    import rbf_pkg::*;

    logic                 prod_valid_reg;
    logic [PROD_BITS-1:0] prod_reg;
    logic                 prod_last_reg;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;
    logic                 out_free;
    logic                 prod_free;
    out_item_t            out_item_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign prod_free = !prod_valid_reg || out_free;
    assign acc_ready = prod_free;

    // truncate the fraction, saturate at the sample range
    always_comb
    begin
        out_item_next.last_of_row = prod_last_reg;
        if (|prod_reg[PROD_BITS-1:RECIP_FRAC+SAMPLE_BITS])
        begin
            out_item_next.mean = '1;
        end
        else
        begin
            out_item_next.mean = prod_reg[RECIP_FRAC+SAMPLE_BITS-1:RECIP_FRAC];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_free)
            begin
                prod_valid_reg <= acc_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_free && acc_valid)
        begin
            prod_reg      <= PROD_BITS'(acc_item.sum) * PROD_BITS'(recip);
            prod_last_reg <= acc_item.last;
        end
        if (out_free && prod_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: src/row_box_filter_edge_replicate.sv
// path: a window sum is registered in the sum stage, then the product register, then the output register
// throughput: one item per cycle while the output is not stalled; a row end with radius k adds k flush steps
// in which the window line keeps shifting and no item is taken
// reset: asynchronous active low; clears sum, position, phase and valid flags,
// radius returns to 1 and reciprocal to 5592405; window cells are not cleared
module row_box_filter_edge_replicate (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rbf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [rbf_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rbf_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rbf_pkg::out_item_t                out_item
);
    import rbf_pkg::*;

    // configuration
    logic [HW_BITS-1:0]    half_width_reg;
    logic [RECIP_BITS-1:0] recip_reg;

    // row sequencer state
    phase_t                 phase_reg, phase_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [HW_BITS-1:0]     flush_cnt_reg, flush_cnt_next;
    logic [SAMPLE_BITS-1:0] hold_reg;
    logic [SAMPLE_BITS-1:0] first_reg, first_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;

    // window sum stage feeding the scaler
    logic                   acc_valid_reg, acc_last_reg;
    logic                   scale_ready;
    acc_item_t              acc_item;

    // control
    logic                   flushing;
    logic                   stage_free;
    logic                   step_en;
    logic                   emit;
    logic                   emit_last;
    logic [SAMPLE_BITS-1:0] step_sample;
    logic [SAMPLE_BITS-1:0] tap;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [POS_BITS-1:0]    k_ext;
    logic [POS_BITS-1:0]    win_len;
    logic [POS_BITS-1:0]    k_plus;
    logic [POS_BITS-1:0]    pos_inc;
    logic                   flush_done;

    // window shift line: cell i holds the sample taken i steps ago
    logic [SAMPLE_BITS-1:0] win_q [WIN_DEPTH];

    // the user must write config only while idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= HALF_WIDTH_RESET;
            recip_reg      <= RECIP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HALF_WIDTH: half_width_reg <= cfg_data[HW_BITS-1:0];
                CFG_RECIP:      recip_reg      <= cfg_data[RECIP_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // next phase: a row end with nonzero radius opens a flush of k steps
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_STREAM:
            begin
                if (step_en && in_item.row_end && half_width_reg != '0)
                begin
                    phase_next = PH_FLUSH;
                end
            end
            PH_FLUSH:
            begin
                if (step_en && flush_done)
                begin
                    phase_next = PH_STREAM;
                end
            end
            default: phase_next = PH_STREAM;
        endcase
    end

    // phase outputs
    always_comb
    begin
        flushing = 1'b0;
        in_ready = 1'b0;
        unique case (phase_reg)
            PH_STREAM:
            begin
                in_ready = stage_free;
            end
            PH_FLUSH:
            begin
                flushing = 1'b1;
            end
            default: ;
        endcase
    end

    // the sum stage may move when its result has gone or is leaving now
    assign stage_free = !acc_valid_reg || scale_ready;
    assign step_en    = stage_free && (flushing || in_valid);

    // during flush the row's last sample is replicated into the line
    assign step_sample = flushing ? hold_reg : in_item.sample;

    // sample leaving the window sits at cell 2k before the shift
    assign tap        = win_q[{half_width_reg, 1'b0}];
    assign k_ext      = {1'b0, half_width_reg};
    assign win_len    = {half_width_reg, 1'b1};
    assign k_plus     = k_ext + POS_BITS'(1);
    assign pos_inc    = (pos_reg == POS_BITS'(POS_LIMIT)) ? pos_reg : pos_reg + POS_BITS'(1);
    assign flush_done = (flush_cnt_reg == half_width_reg);
    // before the row start the first pixel stands in for missing samples
    assign old_sample = (pos_reg >= win_len) ? tap : first_reg;

    genvar gi;
    generate
        for (gi = 0; gi < WIN_DEPTH; gi++)
        begin : g_win
            if (gi == 0)
            begin : g_head
                rbf_cell u_cell (
                    .clk   (clk),
                    .shift (step_en),
                    .d     (step_sample),
                    .q     (win_q[gi])
                );
            end
            else
            begin : g_body
                rbf_cell u_cell (
                    .clk   (clk),
                    .shift (step_en),
                    .d     (win_q[gi-1]),
                    .q     (win_q[gi])
                );
            end
        end
    endgenerate

    // running sum update and result scheduling for one step
    always_comb
    begin
        first_next     = first_reg;
        sum_next       = sum_reg + SUM_BITS'(step_sample) - SUM_BITS'(old_sample);
        pos_next       = pos_inc;
        flush_cnt_next = flush_cnt_reg;
        emit           = 1'b1;
        emit_last      = 1'b0;
        if (flushing)
        begin
            emit_last      = flush_done;
            flush_cnt_next = flush_cnt_reg + HW_BITS'(1);
            if (flush_done)
            begin
                pos_next = '0;
            end
        end
        else
        begin
            if (pos_reg == '0)
            begin
                // left edge: first pixel counted k+1 times
                first_next = step_sample;
                sum_next   = SUM_BITS'(step_sample) * SUM_BITS'(k_plus);
            end
            else if (pos_reg <= k_ext)
            begin
                sum_next = sum_reg + SUM_BITS'(step_sample);
            end
            emit      = (pos_reg >= k_ext) || in_item.row_end;
            emit_last = in_item.row_end && (half_width_reg == '0);
            if (in_item.row_end)
            begin
                flush_cnt_next = HW_BITS'(1);
                if (half_width_reg == '0)
                begin
                    pos_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_STREAM;
            pos_reg       <= '0;
            flush_cnt_reg <= '0;
            first_reg     <= '0;
            sum_reg       <= '0;
            acc_valid_reg <= 1'b0;
            acc_last_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (step_en)
            begin
                pos_reg       <= pos_next;
                flush_cnt_reg <= flush_cnt_next;
                first_reg     <= first_next;
                sum_reg       <= sum_next;
                acc_valid_reg <= emit;
                acc_last_reg  <= emit_last;
            end
            else if (scale_ready)
            begin
                acc_valid_reg <= 1'b0;
            end
        end
    end

    // row end sample kept for replication during the flush
    always_ff @(posedge clk)
    begin
        if (step_en && !flushing)
        begin
            hold_reg <= in_item.sample;
        end
    end

    assign acc_item.sum  = sum_reg;
    assign acc_item.last = acc_last_reg;

    rbf_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .recip     (recip_reg),
        .acc_valid (acc_valid_reg),
        .acc_ready (scale_ready),
        .acc_item  (acc_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// File: src/rbf_checker.sv
// port checker for the row box filter, bound to the top level
// uses rbf_pkg; watches only the top level ports
module rbf_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rbf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [rbf_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  rbf_pkg::in_item_t                 in_item,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  rbf_pkg::out_item_t                out_item
);
    import rbf_pkg::*;

    // shadow of the radius register
    logic [HW_BITS-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= HALF_WIDTH_RESET;
        end
        else if (cfg_we && cfg_index == CFG_HALF_WIDTH)
        begin
            radius_reg <= cfg_data[HW_BITS-1:0];
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // input side keeps its item offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_item))
        else $error("input item dropped while stalled");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present after reset");

    // a row end with nonzero radius starts a flush that blocks input
    a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_item.row_end && radius_reg != '0 |=> !in_ready)
        else $error("input taken during row flush");

endmodule

bind row_box_filter_edge_replicate rbf_checker u_rbf_checker (.*);
